// ----- src/joystick_drive_mixer_assert.svh -----
// Assertion macros of the joystick drive mixer, used by the controller
`ifndef JOYSTICK_DRIVE_MIXER_ASSERT_SVH
`define JOYSTICK_DRIVE_MIXER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define JDM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define JDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/jdm_pkg.sv -----
// Shared widths, register codes and control structs of the joystick drive mixer
`default_nettype none

package jdm_pkg;

  localparam int AXIS_W  = 11;  // joystick reading and limit registers
  localparam int DB_W    = 9;   // dead band
  localparam int EDGE_W  = 12;  // centre plus or minus dead band
  localparam int DIFF_W  = 13;  // distances between readings and edges
  localparam int SPAN_W  = 11;  // output span of a linear map
  localparam int PROD_W  = 24;  // signed numerator
  localparam int NUM_W   = 22;  // numerator magnitude
  localparam int DEN_W   = 12;  // denominator magnitude
  localparam int QUO_W   = 23;  // signed quotient
  localparam int RES_W   = 24;  // quotient plus start speed
  localparam int SPEED_W = 11;  // signed axis speed and held run speed
  localparam int MIX_W   = 12;  // signed motor value after mixing
  localparam int DUTY_W  = 8;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 24;

  typedef enum logic [2:0] {
    REG_Y_UPPER,
    REG_Y_CENTRE,
    REG_Y_LOWER,
    REG_X_UPPER,
    REG_X_CENTRE,
    REG_X_LOWER,
    REG_DEAD_BAND,
    REG_DRIVE_MODE
  } reg_idx_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] y_upper;
    logic signed [AXIS_W-1:0] y_centre;
    logic signed [AXIS_W-1:0] y_lower;
    logic signed [AXIS_W-1:0] x_upper;
    logic signed [AXIS_W-1:0] x_centre;
    logic signed [AXIS_W-1:0] x_lower;
    logic        [DB_W-1:0]   dead_band;
    logic                     drive_mode;
  } cfg_t;

  typedef struct packed {
    logic cap_in;     // take the joystick item
    logic cap_clamp;  // register clamped distances and spans
    logic cap_prod;   // register the numerators
    logic div_start;  // launch both dividers
    logic cap_map;    // register the mapped axis speeds
    logic cap_mix;    // update held run speed and motor values
    logic load_out;   // load the result register
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } stat_t;

endpackage

`default_nettype wire

// ----- src/joystick_drive_mixer.sv -----
// Top level of the joystick drive mixer: register bank, controller and datapath
//
//   channel  | direction | payload
//   ---------+-----------+--------------------------------------------------
//   s_axis   | in        | s_tdata: axis_forward, axis_turn (signed, 11 each)
//   m_axis   | out       | m_tdata: left_reverse, left_duty, right_reverse,
//            |           |          right_duty
//   apb      | in/out    | eight registers at byte addresses 0, 4, .. 28
//
// Each item passes through clamp, multiply and divider start, then waits in the
// divide state while both dividers, one per axis side by side, produce the 22
// quotient bits, then moves through map, mix and result load back to idle.
// The result sits in an output register, so the next item is accepted while it
// waits; the block stalls only when a new result is ready and the old one waits.
// Reset clears the config registers, held run speed, state and output valid flag.
`default_nettype none

module joystick_drive_mixer #(
  parameter int TOP_SPEED        = 255,
  parameter int MIN_MOVING_SPEED = 50,
  parameter int TURN_SPEED_CAP   = 200
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // streaming input
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // [10:0] axis_forward, [21:11] axis_turn, [23:22] zero
  input  wire logic [jdm_pkg::IN_W-1:0]      s_tdata,
  // streaming output
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [0] left_reverse, [8:1] left_duty, [9] right_reverse, [17:10] right_duty,
  // [23:18] zero
  output logic      [jdm_pkg::OUT_W-1:0]     m_tdata,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [jdm_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [jdm_pkg::PDATA_W-1:0]   pwdata,
  output logic      [jdm_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);
  import jdm_pkg::*;

  cfg_t     cfg;
  cmd_t     cmd;
  stat_t    stat;
  reg_idx_t reg_idx;
  logic     cfg_write;

  logic              left_reverse;
  logic [DUTY_W-1:0] left_duty;
  logic              right_reverse;
  logic [DUTY_W-1:0] right_duty;

  // Registers are word aligned; the low address bits are ignored
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Register bank: write on the access cycle of an APB write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_Y_UPPER:    cfg.y_upper    <= pwdata[AXIS_W-1:0];
        REG_Y_CENTRE:   cfg.y_centre   <= pwdata[AXIS_W-1:0];
        REG_Y_LOWER:    cfg.y_lower    <= pwdata[AXIS_W-1:0];
        REG_X_UPPER:    cfg.x_upper    <= pwdata[AXIS_W-1:0];
        REG_X_CENTRE:   cfg.x_centre   <= pwdata[AXIS_W-1:0];
        REG_X_LOWER:    cfg.x_lower    <= pwdata[AXIS_W-1:0];
        REG_DEAD_BAND:  cfg.dead_band  <= pwdata[DB_W-1:0];
        REG_DRIVE_MODE: cfg.drive_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back: limits sign-extended, dead band and mode zero-extended
  always_comb begin
    unique case (reg_idx)
      REG_Y_UPPER:    prdata = PDATA_W'(cfg.y_upper);
      REG_Y_CENTRE:   prdata = PDATA_W'(cfg.y_centre);
      REG_Y_LOWER:    prdata = PDATA_W'(cfg.y_lower);
      REG_X_UPPER:    prdata = PDATA_W'(cfg.x_upper);
      REG_X_CENTRE:   prdata = PDATA_W'(cfg.x_centre);
      REG_X_LOWER:    prdata = PDATA_W'(cfg.x_lower);
      REG_DEAD_BAND:  prdata = PDATA_W'(cfg.dead_band);
      REG_DRIVE_MODE: prdata = PDATA_W'(cfg.drive_mode);
      default:        prdata = '0;
    endcase
  end

  // Sequencer: one item at a time, result register decoupled from the input
  jdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Arithmetic: clamp, dead zone, two parallel linear maps, sticky speed, mix
  jdm_datapath #(
    .TOP_SPEED        (TOP_SPEED),
    .MIN_MOVING_SPEED (MIN_MOVING_SPEED),
    .TURN_SPEED_CAP   (TURN_SPEED_CAP)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg           (cfg),
    .axis_forward  (s_tdata[AXIS_W-1:0]),
    .axis_turn     (s_tdata[2*AXIS_W-1:AXIS_W]),
    .left_reverse  (left_reverse),
    .left_duty     (left_duty),
    .right_reverse (right_reverse),
    .right_duty    (right_duty)
  );

  // Pack the result, first field in the lowest bit
  assign m_tdata = {{(OUT_W-2-2*DUTY_W){1'b0}},
                    right_duty, right_reverse, left_duty, left_reverse};

endmodule

`default_nettype wire

// ----- src/jdm_div.sv -----
// Shift-subtract unsigned divider, one quotient bit per cycle
`default_nettype none

module jdm_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [jdm_pkg::NUM_W-1:0]  num,
  input  wire logic [jdm_pkg::DEN_W-1:0]  den,
  output logic                            busy,
  output logic      [jdm_pkg::NUM_W-1:0]  quo
);
  import jdm_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] trial;
  logic             fits;

  always_comb begin
    shifted = {rem, acc[NUM_W-1]};
    trial   = {1'b0, shifted} - {2'b00, den_r};
    fits    = ~trial[DEN_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      den_r <= den;
      acc   <= num;
      cnt   <= CNT_W'(NUM_W - 1);
    end else if (busy) begin
      rem <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      acc <= {acc[NUM_W-2:0], fits};
      cnt <= cnt - 1'b1;
    end
  end

  assign quo = acc;

endmodule

`default_nettype wire

// ----- src/jdm_datapath.sv -----
// Datapath: axis clamp, dead zone, linear map, sticky run speed, mixing, duty
`default_nettype none

module jdm_datapath #(
  parameter int TOP_SPEED        = 255,
  parameter int MIN_MOVING_SPEED = 50,
  parameter int TURN_SPEED_CAP   = 200
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire jdm_pkg::cmd_t                     cmd,
  output jdm_pkg::stat_t                         stat,
  input  wire jdm_pkg::cfg_t                     cfg,
  input  wire logic signed [jdm_pkg::AXIS_W-1:0] axis_forward,
  input  wire logic signed [jdm_pkg::AXIS_W-1:0] axis_turn,
  output logic                                   left_reverse,
  output logic             [jdm_pkg::DUTY_W-1:0] left_duty,
  output logic                                   right_reverse,
  output logic             [jdm_pkg::DUTY_W-1:0] right_duty
);
  import jdm_pkg::*;

  localparam logic signed [SPEED_W-1:0] MIN_S    = SPEED_W'(MIN_MOVING_SPEED);
  localparam logic signed [SPEED_W-1:0] CAP_S    = SPEED_W'(TURN_SPEED_CAP);
  localparam logic signed [RES_W-1:0]   TOP_R    = RES_W'(TOP_SPEED);
  localparam logic signed [SPAN_W-1:0]  SPAN_POS = SPAN_W'(TOP_SPEED - MIN_MOVING_SPEED);
  localparam logic        [MIX_W-1:0]   TOP_U    = MIX_W'(TOP_SPEED);
  localparam logic        [MIX_W-1:0]   DUTY_MAX = MIX_W'(255);

  function automatic logic signed [SPEED_W-1:0] clamp_s(
    input logic signed [SPEED_W-1:0] v,
    input logic signed [SPEED_W-1:0] lo,
    input logic signed [SPEED_W-1:0] hi
  );
    logic signed [SPEED_W-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // {duty, reverse}
  function automatic logic [DUTY_W:0] motor(input logic signed [MIX_W-1:0] v);
    logic [MIX_W-1:0] mag;
    logic [MIX_W-1:0] d;
    mag = v[MIX_W-1] ? MIX_W'(-v) : MIX_W'(v);
    if (mag > TOP_U) begin
      mag = TOP_U;
    end
    if (v > 0) begin
      d = mag;
    end else if (v < 0) begin
      d = TOP_U - mag;
    end else begin
      d = '0;
    end
    if (d > DUTY_MAX) begin
      d = DUTY_MAX;
    end
    return {d[DUTY_W-1:0], v[MIX_W-1]};
  endfunction

  // Lane 0 is the forward axis, lane 1 the turn axis
  logic signed [AXIS_W-1:0]  in_r   [2];
  logic signed [AXIS_W-1:0]  lim_hi [2];
  logic signed [AXIS_W-1:0]  lim_c  [2];
  logic signed [AXIS_W-1:0]  lim_lo [2];
  logic signed [EDGE_W-1:0]  db_s;

  logic signed [AXIS_W-1:0]  vc     [2];
  logic signed [EDGE_W-1:0]  hi_edge[2];
  logic signed [EDGE_W-1:0]  lo_edge[2];
  logic signed [EDGE_W-1:0]  in0    [2];
  logic signed [EDGE_W-1:0]  in1    [2];
  logic                      above  [2];
  logic                      below  [2];
  logic signed [DIFF_W-1:0]  diff_c [2];
  logic signed [DIFF_W-1:0]  den_c  [2];

  logic signed [DIFF_W-1:0]  diff_r [2];
  logic signed [DIFF_W-1:0]  den_r  [2];
  logic signed [SPAN_W-1:0]  span_r [2];
  logic signed [SPEED_W-1:0] o0_r   [2];
  logic                      move_r [2];
  logic signed [PROD_W-1:0]  prod_r [2];

  logic        [NUM_W-1:0]   num_mag[2];
  logic        [DEN_W-1:0]   den_mag[2];
  logic        [NUM_W-1:0]   quo    [2];
  logic        [1:0]         busy;

  logic signed [QUO_W-1:0]   qs     [2];
  logic signed [RES_W-1:0]   res    [2];
  logic signed [SPEED_W-1:0] spd_c  [2];
  logic signed [SPEED_W-1:0] spd_r  [2];

  logic                      pass;
  logic signed [SPEED_W-1:0] held;
  logic signed [SPEED_W-1:0] held_next;
  logic signed [MIX_W-1:0]   run;
  logic signed [MIX_W-1:0]   lr;
  logic signed [MIX_W-1:0]   lv_next;
  logic signed [MIX_W-1:0]   rv_next;
  logic signed [MIX_W-1:0]   lv_r;
  logic signed [MIX_W-1:0]   rv_r;
  logic        [DUTY_W:0]    left_m;
  logic        [DUTY_W:0]    right_m;

  always_comb begin
    lim_hi[0] = cfg.y_upper;
    lim_c[0]  = cfg.y_centre;
    lim_lo[0] = cfg.y_lower;
    lim_hi[1] = cfg.x_upper;
    lim_c[1]  = cfg.x_centre;
    lim_lo[1] = cfg.x_lower;
    db_s      = $signed({{(EDGE_W-DB_W){1'b0}}, cfg.dead_band});
    pass      = (cfg.y_upper == '0) && (cfg.y_lower == '0) &&
                (cfg.x_upper == '0) && (cfg.x_lower == '0);
  end

  // Clamp, dead zone and map operands for both axes
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      vc[i]      = clamp_s(in_r[i], lim_lo[i], lim_hi[i]);
      hi_edge[i] = EDGE_W'(lim_c[i]) + db_s;
      lo_edge[i] = EDGE_W'(lim_c[i]) - db_s;
      above[i]   = EDGE_W'(vc[i]) > hi_edge[i];
      below[i]   = EDGE_W'(vc[i]) < lo_edge[i];
      in0[i]     = above[i] ? hi_edge[i] : lo_edge[i];
      in1[i]     = above[i] ? EDGE_W'(lim_hi[i]) : EDGE_W'(lim_lo[i]);
      diff_c[i]  = DIFF_W'(vc[i]) - DIFF_W'(in0[i]);
      den_c[i]   = DIFF_W'(in1[i]) - DIFF_W'(in0[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_r[0] <= axis_forward;
      in_r[1] <= axis_turn;
    end
    for (int i = 0; i < 2; i++) begin
      if (cmd.cap_clamp) begin
        diff_r[i] <= diff_c[i];
        den_r[i]  <= den_c[i];
        span_r[i] <= above[i] ? SPAN_POS : -SPAN_POS;
        o0_r[i]   <= above[i] ? MIN_S : -MIN_S;
        move_r[i] <= above[i] | below[i];
      end
      if (cmd.cap_prod) begin
        prod_r[i] <= PROD_W'(diff_r[i]) * PROD_W'(span_r[i]);
      end
    end
  end

  // Magnitudes into the dividers, signed result and saturation out of them
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      num_mag[i] = prod_r[i][PROD_W-1] ? NUM_W'(-prod_r[i]) : NUM_W'(prod_r[i]);
      den_mag[i] = den_r[i][DIFF_W-1] ? DEN_W'(-den_r[i]) : DEN_W'(den_r[i]);
      qs[i]      = $signed({1'b0, quo[i]});
      if (prod_r[i][PROD_W-1] ^ den_r[i][DIFF_W-1]) begin
        qs[i] = -qs[i];
      end
      if (den_r[i] == '0) begin
        res[i] = RES_W'(o0_r[i]);
      end else begin
        res[i] = RES_W'(qs[i]) + RES_W'(o0_r[i]);
      end
      if (res[i] > TOP_R) begin
        res[i] = TOP_R;
      end else if (res[i] < -TOP_R) begin
        res[i] = -TOP_R;
      end
      spd_c[i] = move_r[i] ? SPEED_W'(res[i]) : '0;
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_div
    jdm_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (cmd.div_start),
      .num   (num_mag[g]),
      .den   (den_mag[g]),
      .busy  (busy[g]),
      .quo   (quo[g])
    );
  end

  assign stat.div_busy = |busy;

  always_ff @(posedge clk) begin
    if (cmd.cap_map) begin
      spd_r[0] <= spd_c[0];
      spd_r[1] <= spd_c[1];
    end
  end

  // Sticky run speed and car or tank mixing, or pass-through when all limits are zero
  always_comb begin
    if (spd_r[1] == '0 || held == '0) begin
      held_next = spd_r[0];
    end else if (held > 0) begin
      held_next = clamp_s(held, MIN_S, CAP_S);
    end else begin
      held_next = clamp_s(held, -CAP_S, -MIN_S);
    end
    run = MIX_W'(held_next);
    lr  = MIX_W'(spd_r[1]);
    if (!cfg.drive_mode) begin
      lv_next = run;
      rv_next = lr;
    end else if (run == '0 && lr != '0) begin
      lv_next = lr;
      rv_next = -lr;
    end else if (lr == '0) begin
      lv_next = run;
      rv_next = run;
    end else if (run > 0) begin
      if (lr >= 0) begin
        lv_next = run + lr;
        rv_next = run;
      end else begin
        lv_next = run;
        rv_next = run - lr;
      end
    end else begin
      if (lr >= 0) begin
        lv_next = run - lr;
        rv_next = run;
      end else begin
        lv_next = run;
        rv_next = run + lr;
      end
    end
    if (pass) begin
      held_next = held;
      lv_next   = MIX_W'(in_r[0]);
      rv_next   = MIX_W'(in_r[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (cmd.cap_mix) begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_mix) begin
      lv_r <= lv_next;
      rv_r <= rv_next;
    end
  end

  always_comb begin
    left_m  = motor(lv_r);
    right_m = motor(rv_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      left_reverse  <= left_m[0];
      left_duty     <= left_m[DUTY_W:1];
      right_reverse <= right_m[0];
      right_duty    <= right_m[DUTY_W:1];
    end
  end

endmodule

`default_nettype wire

// ----- src/jdm_ctrl.sv -----
// Controller: sequences one item through the datapath and owns the handshakes
`default_nettype none
`include "joystick_drive_mixer_assert.svh"

module jdm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output jdm_pkg::cmd_t       cmd,
  input  wire jdm_pkg::stat_t stat
);
  import jdm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_MAP,
    ST_MIX,
    ST_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        cmd.cap_in = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd.cap_clamp = 1'b1;
        state_next    = ST_MUL;
      end
      ST_MUL: begin
        cmd.cap_prod = 1'b1;
        state_next   = ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (!stat.div_busy) begin
          state_next = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd.cap_map = 1'b1;
        state_next  = ST_MIX;
      end
      ST_MIX: begin
        cmd.cap_mix = 1'b1;
        state_next  = ST_OUT;
      end
      ST_OUT: begin
        cmd.load_out = out_free;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `JDM_ASSERT_SAME(a_start_idle, cmd.div_start, !stat.div_busy, "dividers launched while busy")
  `JDM_ASSERT_SAME(a_load_free, cmd.load_out, out_free, "waiting result overwritten")
  `JDM_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken mid-flight")

endmodule

`default_nettype wire
